/* src/tbba_pkg.sv */
// Shared types, codes and helpers for the typed byte buffer access block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tbba_pkg;

  localparam int unsigned LenW  = 13;
  localparam int unsigned OffW  = 12;
  localparam int unsigned SizeW = 2;
  localparam int unsigned DataW = 64;

  localparam logic [LenW-1:0] LenReset = 13'd4096;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [SizeW-1:0] SIZE_B1 = 2'd0;
  localparam logic [SizeW-1:0] SIZE_B2 = 2'd1;
  localparam logic [SizeW-1:0] SIZE_B4 = 2'd2;
  localparam logic [SizeW-1:0] SIZE_B8 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // input transfer: access memory and latch the command
    logic load_out;  // move the assembled result into the output register
  } ctrl_t;

  function automatic logic [3:0] size_bytes(input logic [SizeW-1:0] code);
    logic [3:0] n;
    case (code)
      SIZE_B1: n = 4'd1;
      SIZE_B2: n = 4'd2;
      SIZE_B4: n = 4'd4;
      SIZE_B8: n = 4'd8;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

/* src/tbba_ctrl.sv */
// Handshake controller for the typed byte buffer access block.
// Depends on tbba_pkg for the command struct.
`timescale 1ns / 1ps

module tbba_ctrl
  import tbba_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_ACCESS
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_xfer;

  always_comb begin
    out_free         = !out_valid_q || out_ready_i;
    in_ready_o       = (state_q == ST_IDLE) || out_free;
    in_xfer          = in_valid_i && in_ready_o;
    cmd_o.capture    = in_xfer;
    cmd_o.load_out   = (state_q == ST_ACCESS) && out_free;

    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        // The held access retires into the output register; a new transfer may
        // arrive in the same cycle.
        if (out_free) begin
          state_d = in_xfer ? ST_ACCESS : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_in_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> state_q == ST_ACCESS)
    else $error("result loaded with no access in flight");

  a_xfer_to_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_ACCESS)
    else $error("accepted transfer did not enter the access state");

  a_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load_out))
    else $error("output valid raised without a result load");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out && out_valid_q |-> out_ready_i)
    else $error("pending result overwritten");

endmodule

/* src/tbba_bank.sv */
// One 64-bit-wide memory bank with byte write enables and a registered read.
// Standalone; instantiated twice by the datapath for even and odd words.
`timescale 1ns / 1ps

module tbba_bank #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       be_i,
  input  logic [63:0]      wdata_i,
  output logic [63:0]      rdata_o
);

  logic [7:0][7:0] mem_q [Depth];
  logic [63:0]     rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < 8; b++) begin
        if (be_i[b]) begin
          mem_q[addr_i][b] <= wdata_i[b*8 +: 8];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tbba_datapath.sv */
// Datapath: length register, range check, byte lane steering and the two banks.
// Depends on tbba_pkg and instantiates tbba_bank.
`timescale 1ns / 1ps

module tbba_datapath
  import tbba_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            cmd_i,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i,
  input  logic             action_i,
  input  logic [SizeW-1:0] access_size_i,
  input  logic [OffW-1:0]  byte_offset_i,
  input  logic             little_endian_i,
  input  logic [DataW-1:0] write_data_i,
  output logic [DataW-1:0] read_data_o,
  output logic             status_o
);

  localparam int unsigned Words     = (STORE_BYTES + 7) / 8;
  localparam int unsigned BankDepth = (Words + 1) / 2;
  localparam int unsigned BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int unsigned CapInt    = (STORE_BYTES > 8191) ? 8191 : STORE_BYTES;
  localparam logic [LenW-1:0] LenCap = LenW'(CapInt);

  logic [LenW-1:0]   len_q;
  logic [LenW-1:0]   valid_len;
  logic [3:0]        nbytes;
  logic [LenW-1:0]   end_addr;
  logic              fail;
  logic [8:0]        word;
  logic [2:0]        off3;
  logic [8:0]        even_addr9;
  logic [BankAw+8:0] even_ext;
  logic [BankAw+7:0] odd_ext;
  logic [BankAw-1:0] even_addr, odd_addr;
  logic [7:0]        mask8;
  logic [7:0][7:0]   acc_bytes;
  logic [127:0]      win_wdata;
  logic [15:0]       win_be;
  logic              mem_we;
  logic [7:0]        even_be, odd_be;
  logic [63:0]       even_wd, odd_wd, even_rd, odd_rd;

  logic              cap_fail_q, cap_write_q, cap_par_q, cap_little_q;
  logic [SizeW-1:0]  cap_size_q;
  logic [2:0]        cap_off_q;

  logic [3:0]        rd_n;
  logic [127:0]      win_rdata;
  logic [127:0]      win_shift;
  logic [7:0][7:0]   rd_bytes;
  logic [7:0][7:0]   val_bytes;
  logic [DataW-1:0]  result;

  logic [DataW-1:0]  out_data_q;
  logic              out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenReset;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    valid_len = (len_q < LenCap) ? len_q : LenCap;
    nbytes    = size_bytes(access_size_i);
    end_addr  = LenW'(byte_offset_i) + LenW'(nbytes);
    fail      = end_addr > valid_len;

    // An access spans at most two adjacent words, one from each bank.
    word       = byte_offset_i[OffW-1:3];
    off3       = byte_offset_i[2:0];
    even_addr9 = {1'b0, word[8:1]} + 9'(word[0]);
    even_ext   = (BankAw+9)'(even_addr9);
    odd_ext    = (BankAw+8)'(word[8:1]);
    even_addr  = even_ext[BankAw-1:0];
    odd_addr   = odd_ext[BankAw-1:0];

    // Put write bytes in address order, then slide them into the 16-byte window.
    mask8 = 8'((9'd1 << nbytes) - 9'd1);
    for (int j = 0; j < 8; j++) begin
      logic [3:0] src;
      src          = little_endian_i ? 4'(j) : (nbytes - 4'd1 - 4'(j));
      acc_bytes[j] = write_data_i[src[2:0]*8 +: 8];
    end
    win_wdata = 128'(acc_bytes) << {off3, 3'b000};
    win_be    = 16'(mask8) << off3;

    mem_we  = cmd_i.capture && (action_i == ACT_WRITE) && !fail;
    even_be = word[0] ? win_be[15:8]     : win_be[7:0];
    odd_be  = word[0] ? win_be[7:0]      : win_be[15:8];
    even_wd = word[0] ? win_wdata[127:64] : win_wdata[63:0];
    odd_wd  = word[0] ? win_wdata[63:0]   : win_wdata[127:64];
  end

  tbba_bank #(
    .Depth (BankDepth),
    .AddrW (BankAw)
  ) u_even_bank (
    .clk_i   (clk_i),
    .re_i    (cmd_i.capture),
    .we_i    (mem_we),
    .addr_i  (even_addr),
    .be_i    (even_be),
    .wdata_i (even_wd),
    .rdata_o (even_rd)
  );

  tbba_bank #(
    .Depth (BankDepth),
    .AddrW (BankAw)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .re_i    (cmd_i.capture),
    .we_i    (mem_we),
    .addr_i  (odd_addr),
    .be_i    (odd_be),
    .wdata_i (odd_wd),
    .rdata_o (odd_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cap_fail_q   <= fail;
      cap_write_q  <= (action_i == ACT_WRITE);
      cap_par_q    <= word[0];
      cap_little_q <= little_endian_i;
      cap_size_q   <= access_size_i;
      cap_off_q    <= off3;
    end
  end

  always_comb begin
    rd_n      = size_bytes(cap_size_q);
    win_rdata = cap_par_q ? {even_rd, odd_rd} : {odd_rd, even_rd};
    win_shift = win_rdata >> {cap_off_q, 3'b000};
    rd_bytes  = win_shift[63:0];
    for (int k = 0; k < 8; k++) begin
      logic [3:0] src;
      src = cap_little_q ? 4'(k) : (rd_n - 4'd1 - 4'(k));
      val_bytes[k] = (4'(k) < rd_n) ? rd_bytes[src[2:0]] : 8'h00;
    end
    result = (cap_write_q || cap_fail_q) ? '0 : DataW'(val_bytes);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= result;
      out_status_q <= cap_fail_q ? STATUS_RANGE : STATUS_OK;
    end
  end

  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;

endmodule

/* src/typed_byte_buffer_access.sv */
// Typed byte buffer access: a byte-addressed store serving 1/2/4/8-byte accesses
// at any offset in either byte order. Usage:
//   Input channel (in_valid_i / in_ready_o) carries one access per transfer:
//   action, size code, byte offset, byte order flag and write data.
//   Output channel (out_valid_o / out_ready_i) returns one result per access:
//   the zero-extended read value and a status bit. Writes return zero data;
//   an access whose last byte reaches the valid length returns status 1,
//   zero data, and leaves the store unchanged.
//   cfg_we_i / cfg_wdata_i set the valid length; write it only while idle.
// An accepted access is held in the bank read registers, then moved into the
// output register when that is free, which raises out_valid_o. The store is
// split into even and odd 64-bit word banks, so any unaligned span is read or
// written with a single access to each bank, and one access per cycle is
// sustained while the receiver keeps out_ready_i high.
// A result waiting in the output register does not block the next transfer;
// only when that register is full and a second access is already fetched does
// in_ready_o drop until the receiver takes the waiting result.
// Reset clears the handshake state and sets the length to 4096 bytes. The
// store contents are undefined until written; no clearing pass is run.
// Depends on tbba_pkg, tbba_ctrl, tbba_datapath and tbba_bank.
`timescale 1ns / 1ps

module typed_byte_buffer_access
  import tbba_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [SizeW-1:0] access_size_i,
  input  logic [OffW-1:0]  byte_offset_i,
  input  logic             little_endian_i,
  input  logic [DataW-1:0] write_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] read_data_o,
  output logic             status_o
);

  ctrl_t cmd;

  tbba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tbba_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .access_size_i   (access_size_i),
    .byte_offset_i   (byte_offset_i),
    .little_endian_i (little_endian_i),
    .write_data_i    (write_data_i),
    .read_data_o     (read_data_o),
    .status_o        (status_o)
  );

endmodule
